// ===== rtl/first_fit_heap_allocator_assert.svh =====
// Assertion macros shared by the checker of the heap allocator.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// Types and constants of the first-fit heap allocator.
// No dependencies; used by the sequencer, the top level and the checker.
package ffha_pkg;

    // Block header layout and the mark written over the link of a taken block.
    localparam int          HDR_BYTES  = 8;
    localparam logic [31:0] MAGIC_WORD = 32'h1979_0822;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [16:0] request_size;
        logic [15:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [15:0] user_address;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIN,
        ST_INIT_W0,
        ST_INIT_W1,
        ST_A_CHECK,
        ST_A_RSZ,
        ST_A_RNX,
        ST_A_EVAL,
        ST_A_REDUCE,
        ST_A_WR_RN,
        ST_A_WR_RS,
        ST_A_WR_CS,
        ST_A_LINK,
        ST_A_MAGIC,
        ST_F_CHECK,
        ST_F_EVAL,
        ST_F_WR_BN,
        ST_F_LINK,
        ST_F_RBS,
        ST_F_BS,
        ST_F_NS,
        ST_F_RNN,
        ST_F_WNN,
        ST_F_CPRE,
        ST_F_CS,
        ST_F_RBN,
        ST_F_WCN
    } t_state;

endpackage

// ===== rtl/ffha_ram.sv =====
// Single-port heap memory, 32-bit words, registered read.
// No dependencies.
module ffha_ram #(
    parameter int  DEPTH = 16384,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ffha_seq.sv =====
// Command sequencer of the heap allocator: walks the free list in the heap
// memory one access per cycle. Depends on ffha_pkg and drives ffha_ram.
module ffha_seq #(
    parameter int  HEAP_BYTES = 65536,
    localparam int AW         = $clog2(HEAP_BYTES / 4)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ffha_pkg::t_in_item  i_item,
    output ffha_pkg::t_seq_stat o_stat,
    output ffha_pkg::t_out_item o_res,
    input  logic                i_res_ready,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_addr,
    output logic [31:0]         o_mem_wdata,
    input  logic [31:0]         i_mem_rdata
);

    import ffha_pkg::*;

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int OW    = $clog2(HEAP_BYTES);
    localparam int LW    = $clog2(HEAP_BYTES + 1);
    localparam int LIMIT = HEAP_BYTES / 8 + 2;
    localparam int SW    = $clog2(LIMIT + 1);
    localparam int RW    = $clog2(WORDS + 32770);
    localparam logic [LW-1:0] END_LINK = LW'(HEAP_BYTES);

    // Every link at or past the heap end ends the walk, so the walk pointer is
    // kept saturated to the end mark. Links that are written back to the heap
    // or to the head keep their full 32-bit value.
    function automatic logic [LW-1:0] f_link(input logic [31:0] v);
        return (v >= 32'(HEAP_BYTES)) ? END_LINK : LW'(v);
    endfunction

    function automatic logic [AW-1:0] f_wnext(input logic [AW-1:0] w);
        return (w == AW'(WORDS - 1)) ? '0 : w + AW'(1);
    endfunction

    t_state          r_state, n_state;
    logic [31:0]     r_head, n_head;
    logic [17:0]     r_size, n_size;
    logic [OW-1:0]   r_blk, n_blk;
    logic [LW-1:0]   r_cur, n_cur;
    logic [OW-1:0]   r_prev, n_prev;
    logic            r_is_head, n_is_head;
    logic [SW-1:0]   r_steps, n_steps;
    logic [31:0]     r_csize, n_csize;
    logic [31:0]     r_bsize, n_bsize;
    logic [31:0]     r_nxt, n_nxt;
    logic [31:0]     r_link, n_link;
    logic [RW-1:0]   r_rest_w, n_rest_w;
    t_out_item       r_res, n_res;

    logic [AW-1:0] cur_w, cur_w1, blk_w, blk_w1, nxt_w, nxt_w1, prev_w, rest_w, rest_w1;
    logic [17:0]   size_sum, size_in;
    logic [15:0]   uaddr;
    logic          free_bad;
    logic [LW-1:0] q_link;
    logic [31:0]   f_nxt;
    logic          steps_out, a_at_end, a_fit, a_whole, rest_over;
    logic          f_here, f_nxt_end, f_merge_n, f_merge_c;
    logic [31:0]   sum_merge;

    assign cur_w   = AW'(r_cur >> 2);
    assign cur_w1  = f_wnext(cur_w);
    assign blk_w   = AW'(r_blk >> 2);
    assign blk_w1  = f_wnext(blk_w);
    assign nxt_w   = AW'(r_nxt >> 2);
    assign nxt_w1  = f_wnext(nxt_w);
    assign prev_w  = AW'(r_prev >> 2);
    assign rest_w  = AW'(r_rest_w);
    assign rest_w1 = f_wnext(rest_w);

    // Request size rounded up to whole words; free address with the low bits dropped.
    assign size_sum = 18'(i_item.request_size) + 18'd3;
    assign size_in  = {size_sum[17:2], 2'b00};
    assign uaddr    = {i_item.block_address[15:2], 2'b00};
    assign free_bad = (uaddr < 16'(HDR_BYTES)) || (32'(uaddr) >= 32'(HEAP_BYTES));

    assign q_link    = f_link(i_mem_rdata);
    assign steps_out = (r_steps == SW'(LIMIT));
    assign a_at_end  = (r_cur >= END_LINK);
    assign a_fit     = (r_csize >= 32'(r_size));
    assign a_whole   = (r_csize < 32'(r_size) + 32'(HDR_BYTES));
    assign rest_over = (r_rest_w >= RW'(WORDS));

    // During the free walk the successor comes from the head register on the
    // first step and from the link word read in the previous cycle after that.
    assign f_nxt     = r_is_head ? r_head : i_mem_rdata;
    assign f_nxt_end = (f_nxt >= 32'(HEAP_BYTES));
    assign f_here    = (r_is_head || (32'(r_blk) > 32'(r_cur)))
                    && (f_nxt_end || (32'(r_blk) < f_nxt));
    assign f_merge_n = (r_nxt < 32'(HEAP_BYTES))
                    && (33'(r_blk) + 33'(HDR_BYTES) + 33'(i_mem_rdata) == 33'(r_nxt));
    assign f_merge_c = (33'(r_cur) + 33'(HDR_BYTES) + 33'(i_mem_rdata) == 33'(r_blk));
    assign sum_merge = i_mem_rdata + r_bsize + 32'(HDR_BYTES);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_item.command)
                        CMD_ALLOC: n_state = ST_A_CHECK;
                        CMD_FREE:  n_state = free_bad ? ST_FIN : ST_F_CHECK;
                        CMD_INIT:  n_state = ST_INIT_W0;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_INIT_W0:  n_state = ST_INIT_W1;
            ST_INIT_W1:  n_state = ST_FIN;
            ST_A_CHECK:  n_state = (steps_out || a_at_end) ? ST_FIN : ST_A_RSZ;
            ST_A_RSZ:    n_state = ST_A_RNX;
            ST_A_RNX:    n_state = ST_A_EVAL;
            ST_A_EVAL: begin
                priority if (!a_fit) begin
                    n_state = ST_A_CHECK;
                end else if (a_whole) begin
                    n_state = ST_A_LINK;
                end else begin
                    n_state = ST_A_REDUCE;
                end
            end
            ST_A_REDUCE: n_state = rest_over ? ST_A_REDUCE : ST_A_WR_RN;
            ST_A_WR_RN:  n_state = ST_A_WR_RS;
            ST_A_WR_RS:  n_state = ST_A_WR_CS;
            ST_A_WR_CS:  n_state = ST_A_LINK;
            ST_A_LINK:   n_state = ST_A_MAGIC;
            ST_A_MAGIC:  n_state = ST_FIN;
            ST_F_CHECK:  n_state = steps_out ? ST_FIN : ST_F_EVAL;
            ST_F_EVAL: begin
                priority if (f_here) begin
                    n_state = ST_F_WR_BN;
                end else if (f_nxt_end) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_F_CHECK;
                end
            end
            ST_F_WR_BN:  n_state = ST_F_LINK;
            ST_F_LINK:   n_state = ST_F_RBS;
            ST_F_RBS:    n_state = ST_F_BS;
            ST_F_BS:     n_state = f_merge_n ? ST_F_NS : ST_F_CPRE;
            ST_F_NS:     n_state = ST_F_RNN;
            ST_F_RNN:    n_state = ST_F_WNN;
            ST_F_WNN:    n_state = ST_F_CPRE;
            ST_F_CPRE:   n_state = r_is_head ? ST_FIN : ST_F_CS;
            ST_F_CS:     n_state = f_merge_c ? ST_F_RBN : ST_FIN;
            ST_F_RBN:    n_state = ST_F_WCN;
            ST_F_WCN:    n_state = ST_FIN;
            ST_FIN:      n_state = i_res_ready ? ST_IDLE : ST_FIN;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Memory port and status outputs.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_addr  = cur_w;
        o_mem_wdata = '0;
        unique case (r_state)
            ST_INIT_W0: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = '0;
                o_mem_wdata = 32'(HEAP_BYTES);
            end
            ST_INIT_W1: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = AW'(1);
                o_mem_wdata = 32'(HEAP_BYTES - HDR_BYTES);
            end
            ST_A_RSZ:   o_mem_addr = cur_w1;
            ST_A_WR_RN: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = rest_w;
                o_mem_wdata = r_nxt;
            end
            ST_A_WR_RS: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = rest_w1;
                o_mem_wdata = r_csize - 32'(HDR_BYTES) - 32'(r_size);
            end
            ST_A_WR_CS: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = cur_w1;
                o_mem_wdata = 32'(r_size);
            end
            ST_A_LINK: begin
                o_mem_we    = !r_is_head;
                o_mem_addr  = prev_w;
                o_mem_wdata = r_link;
            end
            ST_A_MAGIC: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = MAGIC_WORD;
            end
            ST_F_WR_BN: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = blk_w;
                o_mem_wdata = r_nxt;
            end
            ST_F_LINK: begin
                o_mem_we    = !r_is_head;
                o_mem_wdata = 32'(r_blk);
            end
            ST_F_RBS:   o_mem_addr = blk_w1;
            ST_F_BS:    o_mem_addr = nxt_w1;
            ST_F_NS: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = blk_w1;
                o_mem_wdata = sum_merge;
            end
            ST_F_RNN:   o_mem_addr = nxt_w;
            ST_F_WNN: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = blk_w;
                o_mem_wdata = i_mem_rdata;
            end
            ST_F_CPRE:  o_mem_addr = cur_w1;
            ST_F_CS: begin
                o_mem_we    = f_merge_c;
                o_mem_addr  = cur_w1;
                o_mem_wdata = sum_merge;
            end
            ST_F_RBN:   o_mem_addr = blk_w;
            ST_F_WCN: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
        o_stat.idle = (r_state == ST_IDLE);
        o_stat.done = (r_state == ST_FIN) && i_res_ready;
        o_res       = r_res;
    end

    // Datapath registers.
    always_comb begin
        n_head    = r_head;
        n_size    = r_size;
        n_blk     = r_blk;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_is_head = r_is_head;
        n_steps   = r_steps;
        n_csize   = r_csize;
        n_bsize   = r_bsize;
        n_nxt     = r_nxt;
        n_link    = r_link;
        n_rest_w  = r_rest_w;
        n_res     = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_size    = size_in;
                    n_blk     = OW'(32'(uaddr) - 32'(HDR_BYTES));
                    n_cur     = (i_item.command == CMD_ALLOC) ? f_link(r_head) : '0;
                    n_is_head = 1'b1;
                    n_steps   = '0;
                    n_res     = '0;
                end
            end
            ST_INIT_W0: n_head = '0;
            ST_INIT_W1: n_res.granted = 1'b1;
            ST_A_RNX:   n_csize = i_mem_rdata;
            ST_A_EVAL: begin
                n_nxt = i_mem_rdata;
                priority if (!a_fit) begin
                    n_prev    = OW'(r_cur);
                    n_cur     = q_link;
                    n_is_head = 1'b0;
                    n_steps   = r_steps + SW'(1);
                end else if (a_whole) begin
                    n_link = i_mem_rdata;
                end else begin
                    n_link   = 32'(r_cur) + 32'(HDR_BYTES) + 32'(r_size);
                    n_rest_w = RW'(cur_w) + RW'(2) + RW'(r_size >> 2);
                end
            end
            ST_A_REDUCE: begin
                if (rest_over) begin
                    n_rest_w = r_rest_w - RW'(WORDS);
                end
            end
            ST_A_LINK: begin
                if (r_is_head) begin
                    n_head = r_link;
                end
            end
            ST_A_MAGIC: begin
                n_res.granted      = 1'b1;
                n_res.user_address = 16'(32'(r_cur) + 32'(HDR_BYTES));
            end
            ST_F_EVAL: begin
                priority if (f_here) begin
                    n_nxt = f_nxt;
                end else if (!f_nxt_end) begin
                    n_cur     = f_link(f_nxt);
                    n_is_head = 1'b0;
                    n_steps   = r_steps + SW'(1);
                end else begin
                    n_nxt = r_nxt;
                end
            end
            ST_F_WR_BN: n_res.granted = 1'b1;
            ST_F_LINK: begin
                if (r_is_head) begin
                    n_head = 32'(r_blk);
                end
            end
            ST_F_BS:    n_bsize = i_mem_rdata;
            ST_F_NS:    n_bsize = sum_merge;
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= 32'(HEAP_BYTES);
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_blk     <= n_blk;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_is_head <= n_is_head;
        r_steps   <= n_steps;
        r_csize   <= n_csize;
        r_bsize   <= n_bsize;
        r_nxt     <= n_nxt;
        r_link    <= n_link;
        r_rest_w  <= n_rest_w;
        r_res     <= n_res;
    end

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with an address-ordered free list and coalescing.
// Uses ffha_pkg, ffha_seq and ffha_ram.
//
// Usage: one command item (allocate, free or initialize) enters on the input
// channel and exactly one result item (granted, user_address) leaves on the
// output channel. Both channels use valid and stall; an item moves at a rising
// clock edge where valid is high and stall is low.
// The block works on one command at a time. o_in_stall is high from the cycle
// after an item is accepted until its result has been loaded into the output
// register. The output register lets the next command be accepted while the
// previous result is still waiting for the receiver.
// Allocate walks the free blocks in list order and then splits and links the
// chosen block; free walks the list positions up to the insert point and
// then inserts and merges the block. The single heap memory port, one access
// per cycle with a registered read, paces both walks; a split whose remainder
// would land past the heap end repeats the address reduction once per wrap.
// While the receiver stalls a result in the output register and the next one is
// finished, the sequencer holds in its final state and the input stays stalled.
// After reset the free list is empty; an initialize command must come first.
// The heap memory is not cleared by reset.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ffha_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ffha_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    import ffha_pkg::*;

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW    = $clog2(WORDS);

    t_seq_stat     seq_stat;
    t_out_item     seq_res;
    logic          res_ready;
    logic          start;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;

    // A command is taken only while the sequencer is idle.
    assign o_in_stall = !seq_stat.idle;
    assign start      = i_in_valid && seq_stat.idle;

    // The output register can take a new result when empty or being emptied.
    assign res_ready = !r_out_valid || !i_out_stall;

    ffha_seq #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_in_item),
        .o_stat      (seq_stat),
        .o_res       (seq_res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    ffha_ram #(
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (seq_stat.done) begin
            n_out_valid = 1'b1;
            n_out_item  = seq_res;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/ffha_chk.sv =====
// Port-level checker for the heap allocator and its bind to the top level.
// Uses ffha_pkg and the macros of first_fit_heap_allocator_assert.svh.
`include "first_fit_heap_allocator_assert.svh"

module ffha_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input ffha_pkg::t_in_item  i_in_item,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input ffha_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);

    import ffha_pkg::*;

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // Every command moves the sequencer out of its idle state, so the input must close.
    `FFHA_NEXT(a_busy_after_take, in_take, o_in_stall, "input open right after an item")

    // A fresh result only comes out of a command that was in progress.
    `FFHA_HOLDS(a_result_from_work, $rose(o_out_valid), $past(o_in_stall), "result without work")

    // A refused command never reports an address.
    `FFHA_HOLDS(a_refusal_no_addr, o_out_valid && !o_out_item.granted, o_out_item.user_address == 16'd0, "address on refusal")

    // A stalled result stays put.
    `FFHA_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_chk u_chk (.*);
